@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker of the running median unit.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/rmm_pkg.sv @@
// Types and constants of the running median multiset unit.
// Used by the interfaces, controller, datapath, top level and checker.
`timescale 1ns / 1ps

package rmm_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CHK,
    S_REM_RD,
    S_REM_CHK,
    S_SH_RD,
    S_SH_WR,
    S_MED_RD,
    S_MED_WAIT
  } state_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_MEDIAN
  } rd_sel_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic    latch_in;
    logic    status_en;
    status_t status_code;
    logic    idx_load_count;
    logic    idx_clear;
    logic    idx_inc;
    logic    idx_dec;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_from_ram;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } dp_ctl_t;

  // Status from datapath to controller.
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic full;
    logic idx_zero;
    logic idx_last;
    logic rd_gt;
    logic rd_eq;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hdl/rmm_stream_if.sv @@
// Handshake channel interfaces for command input and median result output.
// Depends on rmm_pkg.
`timescale 1ns / 1ps

interface rmm_in_if;
  logic                                valid;
  logic                                ready;
  rmm_pkg::cmd_t                       command;
  logic signed [rmm_pkg::SampleW-1:0]  sample_value;

  modport source (output valid, output command, output sample_value, input ready);
  modport sink   (input valid, input command, input sample_value, output ready);
endinterface

interface rmm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmm_pkg::SampleW-1:0]  median_value;
  logic                                median_valid;
  logic        [rmm_pkg::CountW-1:0]   element_count;
  rmm_pkg::status_t                    status;

  modport source (output valid, output median_value, output median_valid,
                  output element_count, output status, input ready);
  modport sink   (input valid, input median_value, input median_valid,
                  input element_count, input status, output ready);
endinterface

@@ hdl/rmm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module rmm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata_r
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ hdl/rmm_ctrl.sv @@
// Controller state machine of the running median unit.
// Depends on rmm_pkg; drives rmm_datapath through dp_ctl_t.
`timescale 1ns / 1ps

module rmm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmm_pkg::dp_stat_t stat,
  output rmm_pkg::dp_ctl_t  ctl
);

  rmm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rmm_pkg::S_DISPATCH;
      end
      rmm_pkg::S_DISPATCH: begin
        if (stat.cmd == rmm_pkg::CMD_INSERT) begin
          state_nxt = stat.full ? rmm_pkg::S_MED_RD : rmm_pkg::S_INS_RD;
        end else begin
          state_nxt = stat.empty ? rmm_pkg::S_MED_RD : rmm_pkg::S_REM_RD;
        end
      end
      rmm_pkg::S_INS_RD: begin
        state_nxt = stat.idx_zero ? rmm_pkg::S_MED_RD : rmm_pkg::S_INS_CHK;
      end
      rmm_pkg::S_INS_CHK: begin
        state_nxt = stat.rd_gt ? rmm_pkg::S_INS_RD : rmm_pkg::S_MED_RD;
      end
      rmm_pkg::S_REM_RD: state_nxt = rmm_pkg::S_REM_CHK;
      rmm_pkg::S_REM_CHK: begin
        if (stat.rd_eq) state_nxt = rmm_pkg::S_SH_RD;
        else if (stat.idx_last) state_nxt = rmm_pkg::S_MED_RD;
        else state_nxt = rmm_pkg::S_REM_RD;
      end
      rmm_pkg::S_SH_RD: begin
        state_nxt = stat.idx_last ? rmm_pkg::S_MED_RD : rmm_pkg::S_SH_WR;
      end
      rmm_pkg::S_SH_WR:  state_nxt = rmm_pkg::S_SH_RD;
      rmm_pkg::S_MED_RD: state_nxt = rmm_pkg::S_MED_WAIT;
      rmm_pkg::S_MED_WAIT: begin
        if (stat.out_free) state_nxt = rmm_pkg::S_IDLE;
      end
      default: state_nxt = rmm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.rd_sel      = rmm_pkg::RD_IDX;
    ctl.status_code = rmm_pkg::STAT_OK;
    in_ready = 1'b0;
    case (state_r)
      rmm_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        ctl.latch_in = in_valid;
      end
      rmm_pkg::S_DISPATCH: begin
        if (stat.cmd == rmm_pkg::CMD_INSERT) begin
          if (stat.full) begin
            ctl.status_en   = 1'b1;
            ctl.status_code = rmm_pkg::STAT_FULL;
          end else begin
            ctl.idx_load_count = 1'b1;
          end
        end else begin
          if (stat.empty) begin
            ctl.status_en   = 1'b1;
            ctl.status_code = rmm_pkg::STAT_EMPTY;
          end else begin
            ctl.idx_clear = 1'b1;
          end
        end
      end
      rmm_pkg::S_INS_RD: begin
        if (stat.idx_zero) begin
          ctl.wr_en   = 1'b1;
          ctl.cnt_inc = 1'b1;
        end else begin
          ctl.rd_sel = rmm_pkg::RD_IDX_M1;
        end
      end
      rmm_pkg::S_INS_CHK: begin
        ctl.wr_en = 1'b1;
        if (stat.rd_gt) begin
          ctl.wr_from_ram = 1'b1;
          ctl.idx_dec     = 1'b1;
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      rmm_pkg::S_REM_RD: ctl.rd_sel = rmm_pkg::RD_IDX;
      rmm_pkg::S_REM_CHK: begin
        if (!stat.rd_eq) begin
          if (stat.idx_last) begin
            ctl.status_en   = 1'b1;
            ctl.status_code = rmm_pkg::STAT_NOT_FOUND;
          end else begin
            ctl.idx_inc = 1'b1;
          end
        end
      end
      rmm_pkg::S_SH_RD: begin
        if (stat.idx_last) ctl.cnt_dec = 1'b1;
        else ctl.rd_sel = rmm_pkg::RD_IDX_P1;
      end
      rmm_pkg::S_SH_WR: begin
        ctl.wr_en       = 1'b1;
        ctl.wr_from_ram = 1'b1;
        ctl.idx_inc     = 1'b1;
      end
      rmm_pkg::S_MED_RD: ctl.rd_sel = rmm_pkg::RD_MEDIAN;
      rmm_pkg::S_MED_WAIT: begin
        ctl.rd_sel   = rmm_pkg::RD_MEDIAN;
        ctl.out_load = stat.out_free;
      end
      default: ctl = '0;
    endcase
  end

endmodule

@@ hdl/rmm_datapath.sv @@
// Datapath of the running median unit: sorted store, count, index, result register.
// Depends on rmm_pkg and rmm_ram; controlled by rmm_ctrl.
`timescale 1ns / 1ps

module rmm_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rmm_pkg::cmd_t                      in_command,
  input  logic signed [rmm_pkg::SampleW-1:0] in_sample_value,
  input  rmm_pkg::dp_ctl_t                   ctl,
  output rmm_pkg::dp_stat_t                  stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rmm_pkg::SampleW-1:0] out_median_value,
  output logic                               out_median_valid,
  output logic        [rmm_pkg::CountW-1:0]  out_element_count,
  output rmm_pkg::status_t                   out_status
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  rmm_pkg::cmd_t                      cmd_r;
  logic signed [rmm_pkg::SampleW-1:0] value_r;
  logic        [CW-1:0]               count_r;
  logic        [AW-1:0]               idx_r;
  rmm_pkg::status_t                   status_r;

  logic                               out_valid_r;
  logic signed [rmm_pkg::SampleW-1:0] out_median_r;
  logic                               out_mvalid_r;
  logic        [rmm_pkg::CountW-1:0]  out_count_r;
  rmm_pkg::status_t                   out_status_r;

  logic        [AW-1:0]               raddr;
  logic signed [rmm_pkg::SampleW-1:0] rdata;
  logic        [rmm_pkg::SampleW-1:0] wdata;
  logic        [CW:0]                 idx_next_wide;

  rmm_ram #(
    .Width (rmm_pkg::SampleW),
    .Depth (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (ctl.wr_en),
    .waddr   (idx_r),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  always_comb begin
    case (ctl.rd_sel)
      rmm_pkg::RD_IDX:    raddr = idx_r;
      rmm_pkg::RD_IDX_M1: raddr = idx_r - AW'(1);
      rmm_pkg::RD_IDX_P1: raddr = idx_r + AW'(1);
      rmm_pkg::RD_MEDIAN: raddr = AW'(count_r >> 1);
      default:            raddr = idx_r;
    endcase
  end

  assign wdata         = ctl.wr_from_ram ? rdata : value_r;
  assign idx_next_wide = (CW + 1)'(idx_r) + (CW + 1)'(1);

  assign stat.cmd      = cmd_r;
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CW'(CAPACITY));
  assign stat.idx_zero = (idx_r == '0);
  assign stat.idx_last = (idx_next_wide >= (CW + 1)'(count_r));
  assign stat.rd_gt    = (rdata > value_r);
  assign stat.rd_eq    = (rdata == value_r);
  assign stat.out_free = !out_valid_r || out_ready;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.cnt_inc) count_r <= count_r + CW'(1);
      else if (ctl.cnt_dec) count_r <= count_r - CW'(1);
      if (ctl.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_r    <= in_command;
      value_r  <= in_sample_value;
      status_r <= rmm_pkg::STAT_OK;
    end else if (ctl.status_en) begin
      status_r <= ctl.status_code;
    end
    if (ctl.idx_load_count) idx_r <= AW'(count_r);
    else if (ctl.idx_clear) idx_r <= '0;
    else if (ctl.idx_inc) idx_r <= idx_r + AW'(1);
    else if (ctl.idx_dec) idx_r <= idx_r - AW'(1);
    if (ctl.out_load) begin
      out_median_r <= stat.empty ? '0 : rdata;
      out_mvalid_r <= !stat.empty;
      out_count_r  <= rmm_pkg::CountW'(count_r);
      out_status_r <= status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_median_value  = out_median_r;
  assign out_median_valid  = out_mvalid_r;
  assign out_element_count = out_count_r;
  assign out_status        = out_status_r;

endmodule

@@ hdl/running_median_multiset_unit.sv @@
// Running median over a bounded multiset of signed 16-bit samples (top level).
// Depends on rmm_pkg, rmm_stream_if, rmm_ctrl, rmm_datapath and rmm_ram.
//
// Each transfer on in_chan inserts one copy of sample_value or removes one
// copy of it; each produces exactly one transfer on out_chan carrying the
// element at sorted index count/2 (upper middle for even counts), a flag
// that the store is non-empty, the element count (low 7 bits) and a status:
// ok, insert dropped because full, remove from empty, or value not found.
// The samples sit in ascending order in a single RAM with one write port
// and one registered read port, so every compare waits for registered read
// data. An insert walks down from the top, moving each larger element up
// one slot. A remove searches upward and then closes the gap; a remove of
// an absent value searches the whole store. An insert into a full store or
// a remove from an empty one goes straight from dispatch to the median
// read. Items are handled one at a time; the next command is taken once
// the previous result has entered the output register, so a result waiting
// for out_chan.ready does not hold back the next transfer in. A result
// still waiting when the following one is ready holds that one in the
// median wait state.
// No clearing pass is needed after reset: only data below the count is used.
`timescale 1ns / 1ps

module running_median_multiset_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  rmm_in_if.sink   in_chan,
  rmm_out_if.source out_chan
);

  rmm_pkg::dp_ctl_t  ctl;
  rmm_pkg::dp_stat_t stat;

  // Sequencer: walks the store one element per read/compare step.
  rmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Store, count, index and output register.
  rmm_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_command        (in_chan.command),
    .in_sample_value   (in_chan.sample_value),
    .ctl               (ctl),
    .stat              (stat),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_median_value  (out_chan.median_value),
    .out_median_valid  (out_chan.median_valid),
    .out_element_count (out_chan.element_count),
    .out_status        (out_chan.status)
  );

endmodule

@@ hdl/rmm_checker.sv @@
// Port-level checker for the running median unit, bound to the top level.
// Depends on rmm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmm_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_median_valid,
  input logic [rmm_pkg::CountW-1:0]        out_element_count,
  input rmm_pkg::status_t                  out_status
);

  `ASSERT_IMPLIES(a_mvalid_count, clk, rst_n, out_valid, out_median_valid == (out_element_count != '0))
  `ASSERT_IMPLIES(a_full_count, clk, rst_n, out_valid && out_status == rmm_pkg::STAT_FULL, out_element_count == rmm_pkg::CountW'(CAPACITY))
  `ASSERT_IMPLIES(a_empty_none, clk, rst_n, out_valid && out_status == rmm_pkg::STAT_EMPTY, !out_median_valid && out_element_count == '0)
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind running_median_multiset_unit rmm_checker #(
  .CAPACITY (CAPACITY)
) u_rmm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_median_valid  (out_chan.median_valid),
  .out_element_count (out_chan.element_count),
  .out_status        (out_chan.status)
);

@@ tb/rmm_median_checker.sv @@
// Scoreboard for the running median multiset unit: watches both channels.
// Depends on rmm_pkg and the rmm_in_if / rmm_out_if channel interfaces.
`timescale 1ns / 1ps

module rmm_median_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  rmm_in_if           in_mon,
  rmm_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  typedef logic signed [rmm_pkg::SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t                    median_value;
    logic                       median_valid;
    logic [rmm_pkg::CountW-1:0] element_count;
    rmm_pkg::status_t           status;
  } median_rec_t;

  sample_t     held_q[$];      // ascending copy of the multiset
  median_rec_t expected_q[$];  // results still owed by the block
  int unsigned fails = 0;

  // Apply one command to the local multiset and return the result it owes.
  function automatic median_rec_t apply_command(input rmm_pkg::cmd_t cmd, input sample_t v);
    median_rec_t rec;
    int          pos;
    rec.status = rmm_pkg::STAT_OK;
    pos = 0;
    if (cmd == rmm_pkg::CMD_INSERT) begin
      if (held_q.size() >= int'(CAPACITY)) begin
        rec.status = rmm_pkg::STAT_FULL;
      end else begin
        // new copy goes after any equal copies
        while (pos < held_q.size() && held_q[pos] <= v) pos++;
        held_q.insert(pos, v);
      end
    end else if (held_q.size() == 0) begin
      rec.status = rmm_pkg::STAT_EMPTY;
    end else begin
      while (pos < held_q.size() && held_q[pos] != v) pos++;
      if (pos == held_q.size()) begin
        rec.status = rmm_pkg::STAT_NOT_FOUND;
      end else begin
        held_q.delete(pos);
      end
    end
    rec.median_valid  = (held_q.size() != 0);
    rec.median_value  = '0;
    if (rec.median_valid) begin
      rec.median_value = held_q[held_q.size() / 2];
    end
    rec.element_count = rmm_pkg::CountW'(held_q.size());
    return rec;
  endfunction

  always @(posedge clk) begin
    median_rec_t got;
    median_rec_t want;
    if (!rst_n) begin
      held_q.delete();
      expected_q.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        expected_q.insert(expected_q.size(),
                          apply_command(in_mon.command, in_mon.sample_value));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.median_value  = out_mon.median_value;
        got.median_valid  = out_mon.median_valid;
        got.element_count = out_mon.element_count;
        got.status        = out_mon.status;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: unexpected result value %0d valid %0b count %0d status %0d",
                     $realtime, got.median_value, got.median_valid,
                     got.element_count, got.status);
          end
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: result mismatch: expected value %0d valid %0b count %0d status %0d",
                       $realtime, want.median_value, want.median_valid,
                       want.element_count, want.status);
              $display("%0t:                  got      value %0d valid %0b count %0d status %0d",
                       $realtime, got.median_value, got.median_valid,
                       got.element_count, got.status);
            end
          end
        end
      end
      fail_count  <= fails;
      outstanding <= expected_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the running median multiset testbench: stimulus, receiver stalls, verdict.
// Depends on rmm_pkg, the channel interfaces, the unit and rmm_median_checker.
`timescale 1ns / 1ps

module tb_top;

  typedef logic signed [rmm_pkg::SampleW-1:0] sample_t;

  localparam int unsigned Capacity    = 64;
  localparam int unsigned RandomItems = 1930;
  localparam int unsigned SettleWait  = 200;      // covers a full-store remove
  localparam int unsigned Limit       = 2000000;  // cycles before giving up

  logic        clk;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned outstanding;

  rmm_in_if  in_ch ();
  rmm_out_if out_ch ();

  running_median_multiset_unit #(
    .CAPACITY (Capacity)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  rmm_median_checker #(
    .CAPACITY (Capacity)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 2 ns clock period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog: abandon the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= Limit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Values recently inserted: removes draw on these so that most of them hit.
  sample_t recent_inserts[$];

  // Idle length: mostly none, often short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample choice: history for well-formed removes, else a clustered pool,
  // the extremes, duplicates of earlier inserts or a full random word.
  function automatic sample_t pick_sample(input bit for_remove);
    int unsigned r;
    int          offset;
    if (for_remove && recent_inserts.size() != 0 && $urandom_range(0, 99) < 75) begin
      return recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
    end
    r = $urandom_range(0, 99);
    if (r < 20) begin
      offset = int'($urandom_range(0, 8)) - 4;
      return rmm_pkg::SampleW'(offset);
    end
    if (r < 30) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return -16'sd1;
        default: return 16'sd0;
      endcase
    end
    if (r < 40 && recent_inserts.size() != 0) begin
      return recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
    end
    return rmm_pkg::SampleW'($urandom_range(0, 16'hFFFF));
  endfunction

  // Present one command and hold it until the transfer, then idle a while
  // unless the burst runs back to back.
  task automatic send_cmd(input rmm_pkg::cmd_t cmd, input sample_t val,
                          input bit back_to_back);
    int unsigned gap;
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.sample_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == rmm_pkg::CMD_INSERT) begin
      recent_inserts.insert(recent_inserts.size(), val);
      if (recent_inserts.size() > Capacity) void'(recent_inserts.pop_front());
    end
    gap = back_to_back ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every owed result has been transferred.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Receiver: ready in runs, with random stalls between them; some runs are
  // long so that stretches without any back-pressure occur too.
  initial begin
    int unsigned run_len;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned sent;
    int unsigned burst_len;
    int unsigned insert_pct;
    bit          back_to_back;
    int unsigned mix_pct[5];
    mix_pct = '{95, 75, 50, 25, 5};

    in_ch.valid        <= 1'b0;
    in_ch.command      <= rmm_pkg::CMD_INSERT;
    in_ch.sample_value <= '0;
    rst_n              <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: remove from empty, the extremes, equal copies, absent values,
    // alternating bit patterns, and a full drain back to empty.
    send_cmd(rmm_pkg::CMD_REMOVE, 16'sd0,      1'b0);  // store empty
    send_cmd(rmm_pkg::CMD_INSERT, 16'sh7FFF,   1'b0);
    send_cmd(rmm_pkg::CMD_INSERT, 16'sh8000,   1'b0);
    send_cmd(rmm_pkg::CMD_INSERT, 16'sd0,      1'b0);
    send_cmd(rmm_pkg::CMD_INSERT, 16'sd0,      1'b0);  // equal copy
    send_cmd(rmm_pkg::CMD_INSERT, -16'sd1,     1'b0);
    send_cmd(rmm_pkg::CMD_INSERT, 16'sd1,      1'b0);
    send_cmd(rmm_pkg::CMD_REMOVE, 16'sd5,      1'b0);  // absent value
    send_cmd(rmm_pkg::CMD_REMOVE, 16'sd0,      1'b0);  // one copy of two
    send_cmd(rmm_pkg::CMD_REMOVE, 16'sh7FFF,   1'b0);
    send_cmd(rmm_pkg::CMD_REMOVE, 16'sh8000,   1'b0);
    send_cmd(rmm_pkg::CMD_REMOVE, 16'sd12345,  1'b0);  // absent value
    send_cmd(rmm_pkg::CMD_REMOVE, 16'sd0,      1'b0);
    send_cmd(rmm_pkg::CMD_REMOVE, -16'sd1,     1'b0);
    send_cmd(rmm_pkg::CMD_REMOVE, 16'sd1,      1'b0);  // back to empty
    send_cmd(rmm_pkg::CMD_REMOVE, -16'sd1,     1'b0);  // store empty again
    send_cmd(rmm_pkg::CMD_INSERT, 16'sh5555,   1'b0);
    send_cmd(rmm_pkg::CMD_INSERT, 16'shAAAA,   1'b0);
    send_cmd(rmm_pkg::CMD_REMOVE, 16'sh5555,   1'b0);
    send_cmd(rmm_pkg::CMD_REMOVE, 16'shAAAA,   1'b0);
    wait_drained();

    // Fill past capacity first so that dropped inserts turn up early.
    sent = 0;
    repeat (Capacity + 8) begin
      send_cmd(rmm_pkg::CMD_INSERT, pick_sample(1'b0), 1'b0);
      sent++;
    end

    // Bursts with a drifting insert/remove mix: the store swings between
    // full and empty, with most removes aimed at values actually held.
    while (sent < RandomItems) begin
      burst_len    = $urandom_range(30, 150);
      insert_pct   = mix_pct[$urandom_range(0, 4)];
      back_to_back = ($urandom_range(0, 4) == 0);
      repeat (burst_len) begin
        if ($urandom_range(1, 100) <= insert_pct) begin
          send_cmd(rmm_pkg::CMD_INSERT, pick_sample(1'b0), back_to_back);
        end else begin
          send_cmd(rmm_pkg::CMD_REMOVE, pick_sample(1'b1), back_to_back);
        end
      end
      sent += burst_len;
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (SettleWait) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
